// File: design/brth_pkg.sv
// Shared types, codes, constants and the gamma curve table of the breathing LED driver.
`timescale 1ns / 1ps

package brth_pkg;

  // Fixed field widths
  localparam int OP_W         = 3;
  localparam int TOP_W        = 10;
  localparam int LVL_W        = 8;
  localparam int IDLE_CFG_W   = 16;
  localparam int OFFSET_W     = 10;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  // Default parameter values
  localparam int POSITION_BITS_DEF = 10;
  localparam int IDLE_BITS_DEF     = 16;

  localparam logic [LVL_W-1:0] LEVEL_MAX = 8'd255;

  // Register reset values
  localparam logic [TOP_W-1:0]      CYCLE_TOP_RST     = 10'd200;
  localparam logic [LVL_W-1:0]      FLOOR_POWER_RST   = 8'd5;
  localparam logic [LVL_W-1:0]      CEILING_POWER_RST = 8'd255;
  localparam logic [IDLE_CFG_W-1:0] IDLE_LOW_RST      = 16'd0;
  localparam logic [IDLE_CFG_W-1:0] IDLE_HIGH_RST     = 16'd0;

  // Event codes
  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 3'd0,
    OP_BRIGHTEN = 3'd1,
    OP_RELAX    = 3'd2,
    OP_QUELL    = 3'd3,
    OP_RESTORE  = 3'd4,
    OP_PULSE    = 3'd5,
    OP_DIRECT   = 3'd6
  } brth_op_e;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CYCLE_TOP     = 3'd0,
    CFG_FLOOR_POWER   = 3'd1,
    CFG_CEILING_POWER = 3'd2,
    CFG_IDLE_LOW      = 3'd3,
    CFG_IDLE_HIGH     = 3'd4
  } brth_cfg_e;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;     // take the input beat and apply its immediate state update
    logic div_start;  // launch the shared divider
    logic div_level;  // divider operands: 1 ramp product / top, 0 draw / span
    logic mod_load;   // idle count from the draw remainder
    logic mul_load;   // register the ramp product
    logic level_load; // register the clamped ramp level
    logic out_load;   // load the output register
  } brth_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_tick;
    logic is_direct;
    logic need_mod;
    logic div_done;
    logic out_free;
  } brth_sts_t;

  // Gamma curve table, built at elaboration in Q62 fixed point
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
  localparam logic [63:0] CUBE_255    = 64'd16581375;

  typedef logic [LVL_W-1:0] curve_rom_t [256];

  function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Shift-subtract division, used at elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = n;
    for (int i = 0; i < 64; i++) begin
      r = {r[63:0], q[63]};
      q = {q[62:0], 1'b0};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [LVL_W-1:0] curve_entry(input int unsigned v);
    logic [63:0] num;
    logic [63:0] ratio;
    logic [63:0] theta;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] den;
    logic [63:0] scaled;
    logic        stop;
    if (v == 0) return '0;
    if (v >= 255) return LEVEL_MAX;
    num   = 64'(v) * 64'(v) * 64'(v);
    ratio = '0;
    // ratio = v^3 / 255^3
    for (int i = 0; i < 62; i++) begin
      num   = num << 1;
      ratio = ratio << 1;
      if (num >= CUBE_255) begin
        num      = num - CUBE_255;
        ratio[0] = 1'b1;
      end
    end
    theta = q62_mul(HALF_PI_Q62, ratio);
    x2    = q62_mul(theta, theta);
    term  = theta;
    sum   = theta;
    stop  = 1'b0;
    // sine series
    for (int k = 1; k < 40; k++) begin
      if (!stop) begin
        den  = 64'((2 * k) * (2 * k + 1));
        term = udiv64(q62_mul(term, x2), den);
        if (term == 0) begin
          stop = 1'b1;
        end else if (k[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    scaled = (sum >> 8) * 64'd255;
    scaled = scaled >> 54;
    return (scaled > 64'd255) ? LEVEL_MAX : scaled[LVL_W-1:0];
  endfunction

  function automatic curve_rom_t build_rom();
    curve_rom_t rom;
    for (int v = 0; v < 256; v++) begin
      rom[v] = curve_entry(v);
    end
    return rom;
  endfunction

  localparam curve_rom_t CURVE_ROM = build_rom();

endpackage

// File: design/brth_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module brth_div #(
  parameter int DIVIDEND_W = 18,
  parameter int DIVISOR_W  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quot_o,
  output logic [DIVISOR_W-1:0]  rem_o
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dsr_q, dsr_d;
  logic [DIVISOR_W:0]    rem_shift;

  // one shift-subtract step
  always_comb begin
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    dsr_d     = dsr_q;
    rem_shift = {rem_q, quo_q[DIVIDEND_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIVIDEND_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DIVIDEND_W-2:0], 1'b0};
      if (rem_shift >= {1'b0, dsr_q}) begin
        rem_d    = DIVISOR_W'(rem_shift - {1'b0, dsr_q});
        quo_d[0] = 1'b1;
      end else begin
        rem_d = rem_shift[DIVISOR_W-1:0];
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operands and partial results
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

// File: design/brth_datapath.sv
// Datapath: registers, ramp and floor/ceiling state, level arithmetic and output register.
`timescale 1ns / 1ps

module brth_datapath #(
  parameter int POSITION_BITS = brth_pkg::POSITION_BITS_DEF,
  parameter int IDLE_BITS     = brth_pkg::IDLE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [brth_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [brth_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic [brth_pkg::OP_W-1:0]           op_i,
  input  logic signed [brth_pkg::OFFSET_W-1:0] bias_i,
  input  logic signed [brth_pkg::OFFSET_W-1:0] direct_level_i,
  input  logic [brth_pkg::IDLE_CFG_W-1:0]     idle_draw_i,
  input  brth_pkg::brth_cmd_t                 cmd_i,
  output brth_pkg::brth_sts_t                 sts_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [brth_pkg::LVL_W-1:0]          duty_o,
  output logic [brth_pkg::LVL_W-1:0]          linear_level_o
);

  localparam int PW    = POSITION_BITS;
  localparam int TW    = brth_pkg::TOP_W;
  localparam int LW    = brth_pkg::LVL_W;
  localparam int CW    = brth_pkg::IDLE_CFG_W;
  localparam int WW    = ((PW > TW) ? PW : TW) + 2;        // step arithmetic
  localparam int MAG_W = PW + 8;                           // |position * span|
  localparam int DW    = (MAG_W > CW) ? MAG_W : CW;        // divider dividend
  localparam int SW    = PW + 11;                          // level sum
  localparam int ISW   = ((IDLE_BITS > CW) ? IDLE_BITS : CW) + 1;

  // configuration registers
  logic [TW-1:0] cycle_top_q;
  logic [LW-1:0] floor_power_q;
  logic [LW-1:0] ceiling_power_q;
  logic [CW-1:0] idle_low_q;
  logic [CW-1:0] idle_high_q;

  // block state
  logic [PW-1:0]        ramp_q, ramp_d;
  logic                 rising_q, rising_d;
  logic [IDLE_BITS-1:0] idle_left_q, idle_left_d;
  logic [LW-1:0]        floor_q, floor_d;
  logic [LW-1:0]        ceil_q, ceil_d;

  // per-beat work registers
  logic signed [brth_pkg::OFFSET_W-1:0] bias_q;
  logic [CW-1:0]        draw_q;
  logic [MAG_W-1:0]     mag_q;
  logic                 neg_q;
  logic [LW-1:0]        level_q, level_d;
  logic                 out_valid_q;
  logic [LW-1:0]        duty_q;
  logic [LW-1:0]        lin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_top_q     <= brth_pkg::CYCLE_TOP_RST;
      floor_power_q   <= brth_pkg::FLOOR_POWER_RST;
      ceiling_power_q <= brth_pkg::CEILING_POWER_RST;
      idle_low_q      <= brth_pkg::IDLE_LOW_RST;
      idle_high_q     <= brth_pkg::IDLE_HIGH_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        brth_pkg::CFG_CYCLE_TOP:     cycle_top_q     <= cfg_wdata_i[TW-1:0];
        brth_pkg::CFG_FLOOR_POWER:   floor_power_q   <= cfg_wdata_i[LW-1:0];
        brth_pkg::CFG_CEILING_POWER: ceiling_power_q <= cfg_wdata_i[LW-1:0];
        brth_pkg::CFG_IDLE_LOW:      idle_low_q      <= cfg_wdata_i[CW-1:0];
        brth_pkg::CFG_IDLE_HIGH:     idle_high_q     <= cfg_wdata_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // ramp step: one position toward the current end, clamped to 0..top
  logic [TW-1:0] top_eff;
  logic [WW-1:0] top_ext, pos_raw, pos_c;
  logic          pos_zero, pos_at_top, span_pos;

  always_comb begin
    top_eff    = (cycle_top_q == '0) ? TW'(1) : cycle_top_q;
    top_ext    = WW'(top_eff);
    pos_raw    = WW'(ramp_q) + (rising_q ? WW'(1) : {WW{1'b1}});
    if (pos_raw[WW-1]) begin
      pos_c = '0;
    end else if (pos_raw > top_ext) begin
      pos_c = top_ext;
    end else begin
      pos_c = pos_raw;
    end
    pos_zero   = (pos_c == '0);
    pos_at_top = (pos_c == top_ext);
    span_pos   = (idle_high_q > idle_low_q);
  end

  // divider: draw mod span, or |position * span| / top
  logic          div_done;
  logic [DW-1:0] div_quot;
  logic [CW-1:0] div_rem;
  logic [DW-1:0] div_dividend;
  logic [CW-1:0] div_divisor;

  assign div_dividend = cmd_i.div_level ? DW'(mag_q) : DW'(draw_q);
  assign div_divisor  = cmd_i.div_level ? CW'(top_eff) : CW'(idle_high_q - idle_low_q);

  brth_div #(
    .DIVIDEND_W (DW),
    .DIVISOR_W  (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // ramp product and level sum
  logic signed [8:0]     span_s;
  logic signed [PW+9:0]  prod;
  logic [PW+9:0]         prod_abs;
  logic signed [SW-1:0]  q_s;
  logic signed [SW-1:0]  lvl_sum;
  logic [ISW-1:0]        idle_low_ext;
  logic [ISW-1:0]        idle_sum;
  logic [LW:0]           fl_inc, ce_inc, fp_inc;

  always_comb begin
    span_s       = $signed({1'b0, ceil_q}) - $signed({1'b0, floor_q});
    prod         = $signed({1'b0, ramp_q}) * span_s;
    prod_abs     = prod[PW+9] ? (PW+10)'(-prod) : prod;
    q_s          = neg_q ? -$signed(SW'(div_quot)) : $signed(SW'(div_quot));
    lvl_sum      = $signed(SW'(floor_q)) + q_s + SW'(bias_q);
    idle_low_ext = ISW'(idle_low_q);
    idle_sum     = idle_low_ext + ISW'(div_rem);
    fl_inc       = {1'b0, floor_q} + (LW+1)'(1);
    ce_inc       = {1'b0, ceil_q} + (LW+1)'(1);
    fp_inc       = {1'b0, floor_power_q} + (LW+1)'(1);
  end

  // state updates
  always_comb begin
    ramp_d      = ramp_q;
    rising_d    = rising_q;
    idle_left_d = idle_left_q;
    floor_d     = floor_q;
    ceil_d      = ceil_q;
    level_d     = level_q;
    if (cmd_i.accept) begin
      case (op_i)
        brth_pkg::OP_TICK: begin
          if (idle_left_q != '0) begin
            idle_left_d = idle_left_q - IDLE_BITS'(1);
          end else begin
            ramp_d = pos_c[PW-1:0];
            if (pos_zero) idle_left_d = idle_low_ext[IDLE_BITS-1:0];
            if (pos_zero || pos_at_top) rising_d = ~rising_q;
          end
        end
        brth_pkg::OP_BRIGHTEN: begin
          floor_d = (fl_inc < {1'b0, ceiling_power_q}) ? fl_inc[LW-1:0] : ceiling_power_q;
        end
        brth_pkg::OP_RELAX: begin
          floor_d = ({1'b0, floor_q} > fp_inc) ? floor_q - LW'(1) : floor_power_q;
        end
        brth_pkg::OP_QUELL: begin
          ceil_d  = (ceil_q == '0) ? '0 : ceil_q - LW'(1);
          floor_d = '0;
        end
        brth_pkg::OP_RESTORE: begin
          ceil_d = (ce_inc < {1'b0, ceiling_power_q}) ? ce_inc[LW-1:0] : ceiling_power_q;
          if (floor_q < floor_power_q) floor_d = fl_inc[LW-1:0];
        end
        brth_pkg::OP_PULSE: begin
          idle_left_d = '0;
        end
        brth_pkg::OP_DIRECT: begin
          if (direct_level_i[brth_pkg::OFFSET_W-1]) begin
            level_d = '0;
          end else if (direct_level_i > $signed(brth_pkg::OFFSET_W'(brth_pkg::LEVEL_MAX))) begin
            level_d = brth_pkg::LEVEL_MAX;
          end else begin
            level_d = direct_level_i[LW-1:0];
          end
        end
        default: ;
      endcase
    end
    if (cmd_i.mod_load) begin
      idle_left_d = idle_sum[IDLE_BITS-1:0];
    end
    if (cmd_i.level_load) begin
      if (lvl_sum < 0) begin
        level_d = '0;
      end else if (lvl_sum > $signed(SW'(brth_pkg::LEVEL_MAX))) begin
        level_d = brth_pkg::LEVEL_MAX;
      end else begin
        level_d = lvl_sum[LW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_q      <= '0;
      rising_q    <= 1'b1;
      idle_left_q <= '0;
      floor_q     <= brth_pkg::FLOOR_POWER_RST;
      ceil_q      <= brth_pkg::CEILING_POWER_RST;
    end else begin
      ramp_q      <= ramp_d;
      rising_q    <= rising_d;
      idle_left_q <= idle_left_d;
      floor_q     <= floor_d;
      ceil_q      <= ceil_d;
    end
  end

  // beat payload and intermediate results
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      bias_q <= bias_i;
      draw_q <= idle_draw_i;
    end
    if (cmd_i.mul_load) begin
      mag_q <= prod_abs[MAG_W-1:0];
      neg_q <= prod[PW+9];
    end
    level_q <= level_d;
  end

  // output register, curve lookup on load
  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      duty_q <= brth_pkg::CURVE_ROM[level_q];
      lin_q  <= level_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign duty_o         = duty_q;
  assign linear_level_o = lin_q;

  // status toward the controller
  always_comb begin
    sts_o.is_tick   = (op_i == brth_pkg::OP_TICK);
    sts_o.is_direct = (op_i == brth_pkg::OP_DIRECT);
    sts_o.need_mod  = (op_i == brth_pkg::OP_TICK) && (idle_left_q == '0) && pos_zero && span_pos;
    sts_o.div_done  = div_done;
    sts_o.out_free  = out_free;
  end

endmodule

// File: design/brth_ctrl.sv
// Controller: sequences accept, idle draw, product, division and output load.
`timescale 1ns / 1ps

module brth_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  brth_pkg::brth_sts_t sts_i,
  output brth_pkg::brth_cmd_t cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_MOD_GO   = 8'b0000_0010,
    S_MOD_WAIT = 8'b0000_0100,
    S_MUL      = 8'b0000_1000,
    S_DIV_GO   = 8'b0001_0000,
    S_DIV_WAIT = 8'b0010_0000,
    S_SEND     = 8'b0100_0000,
    S_HOLD     = 8'b1000_0000
  } brth_state_e;

  brth_state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.is_tick) begin
            state_d = sts_i.need_mod ? S_MOD_GO : S_MUL;
          end else if (sts_i.is_direct) begin
            state_d = S_SEND;
          end
        end
      end
      S_MOD_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_MOD_WAIT;
      end
      S_MOD_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.mod_load = 1'b1;
          state_d        = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_load = 1'b1;
        state_d        = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_level = 1'b1;
        state_d         = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        cmd_o.div_level = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.level_load = 1'b1;
          state_d          = S_SEND;
        end
      end
      S_SEND: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end else begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // divider completes only while a division is awaited
  a_div_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == S_MOD_WAIT || state_q == S_DIV_WAIT))
    else $error("divider finished outside a wait state");

  // events without a result return to idle at once
  a_no_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && !sts_i.is_tick && !sts_i.is_direct) |=> (state_q == S_IDLE))
    else $error("event without result did not return to idle");

  // a finished level always goes to the output stage
  a_level_to_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV_WAIT && sts_i.div_done) |=> (state_q == S_SEND))
    else $error("level result lost after division");

  // output load only when the output register can take it
  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (sts_i.out_free && (state_q == S_SEND || state_q == S_HOLD)))
    else $error("output overwritten while a beat is pending");

endmodule

// File: design/breathing_led_pwm_driver.sv
// Top level of the breathing LED driver: controller plus datapath.
//
// One event beat is worked on at a time. Brighten, relax, quell, restore,
// pulse and unused codes are applied at accept and give no result. A direct
// level is clamped to 0..255 and sent straight to the output stage. A tick
// registers the ramp product and then scales it by cycle_top in the
// one-bit-per-cycle divider, whose dividend is DW = max(POSITION_BITS+8, 16)
// bits wide (18 at the defaults); a tick that reaches the bottom of the ramp
// with idle_high above idle_low first runs that divider for the idle draw
// modulo. The result sits in an output register, so the block takes the next
// beat while a result waits; it stalls only when a second result is ready and
// the first has not yet been taken. Configuration writes take effect at once
// and belong to idle periods.
`timescale 1ns / 1ps

module breathing_led_pwm_driver #(
  parameter int POSITION_BITS = brth_pkg::POSITION_BITS_DEF,
  parameter int IDLE_BITS     = brth_pkg::IDLE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [brth_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [brth_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [brth_pkg::OP_W-1:0]            op_i,
  input  logic signed [brth_pkg::OFFSET_W-1:0] bias_i,
  input  logic signed [brth_pkg::OFFSET_W-1:0] direct_level_i,
  input  logic [brth_pkg::IDLE_CFG_W-1:0]      idle_draw_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [brth_pkg::LVL_W-1:0]           duty_o,
  output logic [brth_pkg::LVL_W-1:0]           linear_level_o
);

  brth_pkg::brth_cmd_t cmd;
  brth_pkg::brth_sts_t sts;

  brth_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  brth_datapath #(
    .POSITION_BITS (POSITION_BITS),
    .IDLE_BITS     (IDLE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .op_i           (op_i),
    .bias_i         (bias_i),
    .direct_level_i (direct_level_i),
    .idle_draw_i    (idle_draw_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .duty_o         (duty_o),
    .linear_level_o (linear_level_o)
  );

endmodule

// File: tb/testbench.sv
// Self-checking bench for the breathing LED driver: directed and random event beats against an in-bench model.
`timescale 1ns / 1ps

module testbench;
  import brth_pkg::*;

  localparam int HALF_PERIOD      = 10;
  localparam int RESET_CYCLES     = 11;
  localparam int QUIET_LIMIT      = 4000;
  localparam int SETTLE_CYCLES    = 80;
  localparam int RANDOM_PER_PHASE = 215;
  localparam int REPORT_MAX       = 10;

  // Op code 7 has no meaning and must be dropped silently
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  typedef struct packed {
    logic [LVL_W-1:0] duty;
    logic [LVL_W-1:0] linear;
  } level_pair_t;

  // Model of the driver plus the queue of levels still owed by the block
  class breath_scoreboard;
    logic [LVL_W-1:0]             gamma_lut [256];
    level_pair_t                  due_levels [$];
    int                           mismatches;
    // register copies
    logic [TOP_W-1:0]             top_reg;
    logic [LVL_W-1:0]             floor_reg;
    logic [LVL_W-1:0]             ceil_reg;
    logic [IDLE_CFG_W-1:0]        idle_lo_reg;
    logic [IDLE_CFG_W-1:0]        idle_hi_reg;
    // ramp state
    logic [POSITION_BITS_DEF-1:0] pos;
    logic                         rising;
    logic [IDLE_BITS_DEF-1:0]     idle_left;
    logic [LVL_W-1:0]             cur_floor;
    logic [LVL_W-1:0]             cur_ceil;

    function new();
      for (int v = 0; v < 256; v++) gamma_lut[v] = gamma_of(v);
      top_reg     = CYCLE_TOP_RST;
      floor_reg   = FLOOR_POWER_RST;
      ceil_reg    = CEILING_POWER_RST;
      idle_lo_reg = IDLE_LOW_RST;
      idle_hi_reg = IDLE_HIGH_RST;
      pos         = '0;
      rising      = 1'b1;
      idle_left   = '0;
      cur_floor   = FLOOR_POWER_RST;
      cur_ceil    = CEILING_POWER_RST;
      mismatches  = 0;
    endfunction

    // Q62 x Q62 -> Q62, truncated
    function logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
      logic [127:0] prod;
      prod = 128'(a) * 128'(b);
      return prod[125:62];
    endfunction

    // trunc(255*sin(pi/2*(v/255)^3)) by a fixed-point sine series
    function logic [LVL_W-1:0] gamma_of(int v);
      logic [127:0] wide;
      logic [63:0]  ang;
      logic [63:0]  ang_sq;
      logic [63:0]  term;
      logic [63:0]  acc;
      logic [63:0]  scaled;
      if (v <= 0) return '0;
      if (v >= 255) return LEVEL_MAX;
      wide   = (128'(v) * 128'(v) * 128'(v)) << 62;
      wide   = wide / 128'(CUBE_255);
      ang    = qmul(HALF_PI_Q62, wide[63:0]);
      ang_sq = qmul(ang, ang);
      term   = ang;
      acc    = ang;
      for (int k = 1; k < 40; k++) begin
        term = qmul(term, ang_sq) / 64'((2 * k) * (2 * k + 1));
        if (term == 0) break;
        if (k % 2 == 1) acc = acc - term;
        else acc = acc + term;
      end
      scaled = ((acc >> 8) * 64'd255) >> 54;
      return (scaled > 64'd255) ? LEVEL_MAX : scaled[LVL_W-1:0];
    endfunction

    function logic [LVL_W-1:0] clamp255(int x);
      if (x < 0) return '0;
      if (x > 255) return LEVEL_MAX;
      return LVL_W'(x);
    endfunction

    function void write_reg(brth_cfg_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_CYCLE_TOP:     top_reg = val[TOP_W-1:0];
        CFG_FLOOR_POWER:   floor_reg = val[LVL_W-1:0];
        CFG_CEILING_POWER: ceil_reg = val[LVL_W-1:0];
        CFG_IDLE_LOW:      idle_lo_reg = val;
        CFG_IDLE_HIGH:     idle_hi_reg = val;
        default: ;
      endcase
    endfunction

    // Applies one event; returns 1 with the levels when the event yields a result
    function bit advance_breath(logic [OP_W-1:0] op, logic signed [OFFSET_W-1:0] bias,
                                logic signed [OFFSET_W-1:0] direct,
                                logic [IDLE_CFG_W-1:0] draw, output level_pair_t res);
      int top;
      int step;
      int lvl;
      int span;
      top = (top_reg == 0) ? 1 : int'(top_reg);
      res = '0;
      case (op)
        OP_TICK: begin
          if (idle_left != 0) begin
            idle_left = idle_left - 1'b1;
          end else begin
            step = int'(pos) + (rising ? 1 : -1);
            if (step < 0) step = 0;
            if (step > top) step = top;
            pos = POSITION_BITS_DEF'(step);
            // bottom of the ramp: load the idle count from the draw
            if (step == 0) begin
              span = int'(idle_hi_reg) - int'(idle_lo_reg);
              idle_left = idle_lo_reg;
              if (span > 0) idle_left = idle_lo_reg + IDLE_BITS_DEF'(int'(draw) % span);
            end
            if (step == 0 || step == top) rising = ~rising;
          end
          lvl = int'(cur_floor) + (int'(pos) * (int'(cur_ceil) - int'(cur_floor))) / top
                + int'(bias);
          res.linear = clamp255(lvl);
        end
        OP_BRIGHTEN: begin
          cur_floor = (int'(cur_floor) + 1 < int'(ceil_reg)) ? cur_floor + 1'b1 : ceil_reg;
          return 1'b0;
        end
        OP_RELAX: begin
          cur_floor = (int'(cur_floor) - 1 > int'(floor_reg)) ? cur_floor - 1'b1 : floor_reg;
          return 1'b0;
        end
        OP_QUELL: begin
          if (cur_ceil != 0) cur_ceil = cur_ceil - 1'b1;
          cur_floor = '0;
          return 1'b0;
        end
        OP_RESTORE: begin
          cur_ceil = (int'(cur_ceil) + 1 < int'(ceil_reg)) ? cur_ceil + 1'b1 : ceil_reg;
          if (cur_floor < floor_reg) cur_floor = cur_floor + 1'b1;
          return 1'b0;
        end
        OP_PULSE: begin
          idle_left = '0;
          return 1'b0;
        end
        OP_DIRECT: res.linear = clamp255(int'(direct));
        default: return 1'b0;
      endcase
      res.duty = gamma_lut[res.linear];
      return 1'b1;
    endfunction

    function void note_event(logic [OP_W-1:0] op, logic signed [OFFSET_W-1:0] bias,
                             logic signed [OFFSET_W-1:0] direct, logic [IDLE_CFG_W-1:0] draw);
      level_pair_t res;
      if (advance_breath(op, bias, direct, draw, res)) due_levels.push_back(res);
    endfunction

    function void check_result(logic [LVL_W-1:0] duty, logic [LVL_W-1:0] linear);
      level_pair_t want;
      if (due_levels.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result duty=%0d level=%0d with none pending", $time, duty, linear);
        return;
      end
      want = due_levels.pop_front();
      if (want.duty !== duty || want.linear !== linear) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: duty exp %0d got %0d, level exp %0d got %0d", $time,
                   want.duty, duty, want.linear, linear);
      end
    endfunction
  endclass

  logic                        clk_i          = 1'b0;
  logic                        rst_ni         = 1'b0;
  logic                        cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0]       cfg_wdata_i    = '0;
  logic                        in_valid_i     = 1'b0;
  logic                        in_ready_o;
  logic [OP_W-1:0]             op_i           = '0;
  logic signed [OFFSET_W-1:0]  bias_i         = '0;
  logic signed [OFFSET_W-1:0]  direct_level_i = '0;
  logic [IDLE_CFG_W-1:0]       idle_draw_i    = '0;
  logic                        out_valid_o;
  logic                        out_ready_i    = 1'b0;
  logic [LVL_W-1:0]            duty_o;
  logic [LVL_W-1:0]            linear_level_o;

  breath_scoreboard sb;
  int send_idle_pct = 27;
  int recv_idle_pct = 62;
  int quiet_cycles  = 0;

  breathing_led_pwm_driver u_top (.*);

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Result side: random back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result beats go to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(duty_o, linear_level_o);
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // One event beat, with random gaps ahead of it
  task automatic send_event(logic [OP_W-1:0] op, logic signed [OFFSET_W-1:0] bias,
                            logic signed [OFFSET_W-1:0] direct, logic [IDLE_CFG_W-1:0] draw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= op;
    bias_i         <= bias;
    direct_level_i <= direct;
    idle_draw_i    <= draw;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_event(op, bias, direct, draw);
  endtask

  // Drain all pending results, then give any trailing work time to finish
  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (sb.due_levels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_settings(int top, int fp, int cp, int lo, int hi);
    logic [CFG_DATA_W-1:0] vals [5];
    brth_cfg_e             idx;
    vals[CFG_CYCLE_TOP]     = CFG_DATA_W'(top);
    vals[CFG_FLOOR_POWER]   = CFG_DATA_W'(fp);
    vals[CFG_CEILING_POWER] = CFG_DATA_W'(cp);
    vals[CFG_IDLE_LOW]      = CFG_DATA_W'(lo);
    vals[CFG_IDLE_HIGH]     = CFG_DATA_W'(hi);
    for (int n = 0; n < 5; n++) begin
      idx = brth_cfg_e'(n);
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx;
      cfg_wdata_i <= vals[n];
      @(posedge clk_i);
      sb.write_reg(idx, vals[n]);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random mix, mostly ticks; ignored op codes are not counted
  task automatic run_phase(int count);
    int                         sent;
    int                         roll;
    logic [OP_W-1:0]            op;
    logic signed [OFFSET_W-1:0] bias;
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(99);
      if (roll < 55) op = OP_TICK;
      else if (roll < 65) op = OP_DIRECT;
      else if (roll < 71) op = OP_BRIGHTEN;
      else if (roll < 77) op = OP_RELAX;
      else if (roll < 82) op = OP_QUELL;
      else if (roll < 89) op = OP_RESTORE;
      else if (roll < 96) op = OP_PULSE;
      else op = OP_UNUSED;
      // small offsets keep the ramp visible; full-range ones hit the clamp
      if ($urandom_range(3) != 0) bias = OFFSET_W'(int'($urandom_range(40)) - 20);
      else bias = OFFSET_W'($urandom());
      send_event(op, bias, OFFSET_W'($urandom()), IDLE_CFG_W'($urandom()));
      if (op != OP_UNUSED) sent++;
    end
  endtask

  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: clamp edges of the direct level, tick offsets, every op
    send_event(OP_DIRECT, 0, -512, 0);
    send_event(OP_DIRECT, 0, 511, 16'hFFFF);
    send_event(OP_DIRECT, 0, 255, 0);
    send_event(OP_DIRECT, 0, 256, 0);
    send_event(OP_DIRECT, 0, 0, 0);
    send_event(OP_DIRECT, 0, -1, 0);
    send_event(OP_DIRECT, 0, 128, 0);
    send_event(OP_TICK, 0, 0, 16'hFFFF);
    send_event(OP_TICK, 511, 0, 0);
    send_event(OP_TICK, -512, 0, 0);
    send_event(OP_BRIGHTEN, 0, 0, 0);
    send_event(OP_RELAX, 0, 0, 0);
    send_event(OP_RESTORE, 0, 0, 0);
    send_event(OP_QUELL, 0, 0, 0);
    send_event(OP_TICK, 0, 0, 0);
    send_event(OP_RESTORE, 0, 0, 0);
    send_event(OP_PULSE, 0, 0, 0);
    send_event(OP_UNUSED, -1, -1, 16'hFFFF);
    send_event(OP_TICK, 0, 0, 0);
    send_event(OP_DIRECT, 0, 1, 0);

    // Random phases: sender 27 / receiver 62, then swapped, then no idling
    for (int p = 0; p < 6; p++) begin
      quiesce();
      case (p)
        0: apply_settings(1, 0, 255, 0, 0);
        1: apply_settings(6, 10, 200, 2, 9);
        2: apply_settings(0, 255, 0, 100, 50);          // zero top, inverted ranges
        3: apply_settings(9, 40, 90, 0, 65535);         // widest idle draw
        4: apply_settings(1023, 5, 255, 65535, 0);      // full ramp length
        default: apply_settings(3, 128, 255, 0, 5);     // top cut below the position
      endcase
      send_idle_pct = (p < 2) ? 27 : (p < 4) ? 62 : 0;
      recv_idle_pct = (p < 2) ? 62 : (p < 4) ? 27 : 0;
      run_phase(RANDOM_PER_PHASE);
    end

    quiesce();
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
design/brth_pkg.sv
design/brth_div.sv
design/brth_datapath.sv
design/brth_ctrl.sv
design/breathing_led_pwm_driver.sv
tb/testbench.sv
